// ===== rtl/gshare_local_branch_predictor_macros.svh =====
// Assertion macros for the branch predictor RTL.
`ifndef GSHARE_LOCAL_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_LOCAL_BRANCH_PREDICTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GSBP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GSBP_ASSERT(label, prop, msg)
`define GSBP_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/gsbp_pkg.sv =====
// Shared types and constants of the branch predictor.
`default_nettype none
package gsbp_pkg;

  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 2'd0,
    CFG_INDEX_BITS   = 2'd1,
    CFG_HISTORY_BITS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_GLOBAL = 1'b0,
    MODE_LOCAL  = 1'b1
  } mode_e;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN        = 2'd0;
  localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
  localparam ctr_t CTR_MAX        = 2'd3;

  localparam logic [CFG_W-1:0] RST_INDEX_BITS   = 4'd12;
  localparam logic [CFG_W-1:0] RST_HISTORY_BITS = 4'd0;

endpackage
`default_nettype wire

// ===== rtl/gshare_local_branch_predictor.sv =====
// Top level: bimodal / gshare / local-history branch predictor on two-bit counters.
`default_nettype none
`include "gshare_local_branch_predictor_macros.svh"
// One resolved branch (pc, taken) goes in per word and one word (prediction,
// mispredict, counter_index) comes out, in order. The counter table and the
// local history table sit in two single-port-read synchronous memories; a
// branch reads the local history table in its accept cycle (stage A), the
// counter table in stage B, and writes both back in stage C when its result
// is loaded into the output register. Forwarding from the two most recent
// write-backs keeps the chain correct, so a new branch can be taken every
// cycle unless a stalled output word holds the pipeline. The global history
// is updated at accept time, as it depends on the outcome alone. After reset
// a clearing pass over 2**max(MAX_INDEX_BITS, MAX_HISTORY_BITS) addresses
// (4096 by default) fills both memories; no branch is taken during it, while
// configuration writes are.
module gshare_local_branch_predictor #(
  parameter int unsigned MAX_INDEX_BITS   = 12,
  parameter int unsigned MAX_HISTORY_BITS = 12,
  parameter int unsigned PC_WIDTH         = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gsbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gsbp_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [PC_WIDTH-1:0]           pc_i,
  input  wire logic                          taken_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               prediction_o,
  output logic                               mispredict_o,
  output logic [MAX_INDEX_BITS-1:0]          counter_index_o
);

  localparam int unsigned IBW = $clog2(MAX_INDEX_BITS + 1);
  localparam int unsigned HBW = $clog2(MAX_HISTORY_BITS + 1);
  localparam int unsigned CLR_AW =
    (MAX_INDEX_BITS > MAX_HISTORY_BITS) ? MAX_INDEX_BITS : MAX_HISTORY_BITS;
  localparam int unsigned WORD_W = (PC_WIDTH - 2 > CLR_AW) ? PC_WIDTH - 2 : CLR_AW;
  localparam int unsigned CTR_DEPTH = 1 << MAX_INDEX_BITS;
  localparam int unsigned LHT_DEPTH = 1 << MAX_HISTORY_BITS;

  typedef logic [MAX_INDEX_BITS-1:0]   idx_t;
  typedef logic [MAX_HISTORY_BITS-1:0] lidx_t;

  // configuration registers
  logic                        mode_q;
  logic [gsbp_pkg::CFG_W-1:0]  index_bits_q;
  logic [gsbp_pkg::CFG_W-1:0]  history_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= gsbp_pkg::MODE_GLOBAL;
      index_bits_q   <= gsbp_pkg::RST_INDEX_BITS;
      history_bits_q <= gsbp_pkg::RST_HISTORY_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsbp_pkg::CFG_MODE:         mode_q         <= cfg_wdata_i[0];
        gsbp_pkg::CFG_INDEX_BITS:   index_bits_q   <= cfg_wdata_i;
        gsbp_pkg::CFG_HISTORY_BITS: history_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective widths
  logic [IBW-1:0] ib;
  logic [IBW-1:0] hb_g;
  logic [HBW-1:0] hb_l;
  idx_t           imask;
  idx_t           hmask_g;
  lidx_t          lmask;

  always_comb begin
    if (index_bits_q == '0) begin
      ib = IBW'(1);
    end else if (32'(index_bits_q) > MAX_INDEX_BITS) begin
      ib = IBW'(MAX_INDEX_BITS);
    end else begin
      ib = IBW'(index_bits_q);
    end
    if (32'(history_bits_q) > 32'(ib)) begin
      hb_g = ib;
    end else begin
      hb_g = IBW'(history_bits_q);
    end
    if (32'(history_bits_q) > MAX_HISTORY_BITS) begin
      hb_l = HBW'(MAX_HISTORY_BITS);
    end else begin
      hb_l = HBW'(history_bits_q);
    end
    imask   = ~({MAX_INDEX_BITS{1'b1}} << ib);
    hmask_g = ~({MAX_INDEX_BITS{1'b1}} << hb_g);
    lmask   = ~({MAX_HISTORY_BITS{1'b1}} << hb_l);
  end

  // clearing pass
  logic              clr_q;
  logic [CLR_AW-1:0] clr_cnt_q;
  logic              ctr_clr_en;
  logic              lht_clr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == {CLR_AW{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign ctr_clr_en = (clr_cnt_q >> MAX_INDEX_BITS) == '0;
  assign lht_clr_en = (clr_cnt_q >> MAX_HISTORY_BITS) == '0;

  // pipeline control
  logic adv;
  logic a_acc;
  logic b_valid_q;
  logic c_valid_q;
  logic out_valid_q;
  logic c_wr;

  assign adv        = !out_valid_q || !out_stall_i || !c_valid_q;
  assign in_stall_o = clr_q || !adv;
  assign a_acc      = in_valid_i && !in_stall_o;
  assign c_wr       = adv && c_valid_q;

  // stage A: index compute at accept
  logic [WORD_W-1:0]         word;
  logic [MAX_INDEX_BITS-1:0] ghr_q;
  idx_t                      a_gidx;
  lidx_t                     a_lidx;
  idx_t                      ghr_hist;

  assign word     = WORD_W'(pc_i[PC_WIDTH-1:2]);
  assign ghr_hist = ghr_q & hmask_g;
  assign a_lidx   = word[MAX_HISTORY_BITS-1:0] & lmask;

  always_comb begin
    a_gidx = word[MAX_INDEX_BITS-1:0] & imask;
    if (hb_g != '0) begin
      a_gidx = (a_gidx ^ (ghr_hist << (ib - hb_g))) & imask;
    end
  end

  // global history only depends on outcomes, so shift it in at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghr_q <= '0;
    end else if (a_acc && mode_q == gsbp_pkg::MODE_GLOBAL && hb_g != '0) begin
      ghr_q <= ((ghr_hist >> 1) | (MAX_INDEX_BITS'(taken_i) << (hb_g - 1'b1))) & hmask_g;
    end
  end

  // stage B registers
  logic  b_mode_q;
  logic  b_taken_q;
  idx_t  b_gidx_q;
  lidx_t b_lidx_q;

  // stage C registers
  logic           c_mode_q;
  logic           c_taken_q;
  idx_t           c_idx_q;
  lidx_t          c_lidx_q;
  idx_t           c_lht_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_acc;
      c_valid_q <= b_valid_q;
    end
  end

  // memories and their read registers
  gsbp_pkg::ctr_t ctr_mem [CTR_DEPTH];
  idx_t           lht_mem [LHT_DEPTH];
  gsbp_pkg::ctr_t ctr_rd_q;
  idx_t           lht_rd_q;

  // forwarding of the most recent write-backs
  logic           lw_valid_q;
  lidx_t          lw_lidx_q;
  idx_t           lw_data_q;
  logic           clw_valid_q;
  idx_t           clw_idx_q;
  gsbp_pkg::ctr_t clw_data_q;

  idx_t           b_lhist;
  idx_t           b_idx;
  idx_t           b_lht_new;

  always_comb begin
    priority if (c_valid_q && c_mode_q == gsbp_pkg::MODE_LOCAL && c_lidx_q == b_lidx_q) begin
      b_lhist = c_lht_new_q;
    end else if (lw_valid_q && lw_lidx_q == b_lidx_q) begin
      b_lhist = lw_data_q;
    end else begin
      b_lhist = lht_rd_q;
    end
    b_idx     = (b_mode_q == gsbp_pkg::MODE_LOCAL) ? (b_lhist & imask) : b_gidx_q;
    b_lht_new = (((b_lhist & imask) >> 1) | (MAX_INDEX_BITS'(b_taken_q) << (ib - 1'b1)))
                & imask;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_mode_q    <= mode_q;
      b_taken_q   <= taken_i;
      b_gidx_q    <= a_gidx;
      b_lidx_q    <= a_lidx;
      c_mode_q    <= b_mode_q;
      c_taken_q   <= b_taken_q;
      c_idx_q     <= b_idx;
      c_lidx_q    <= b_lidx_q;
      c_lht_new_q <= b_lht_new;
    end
  end

  // stage C: counter update
  gsbp_pkg::ctr_t c_ctr;
  gsbp_pkg::ctr_t c_ctr_new;

  always_comb begin
    c_ctr = (clw_valid_q && clw_idx_q == c_idx_q) ? clw_data_q : ctr_rd_q;
    if (c_taken_q) begin
      c_ctr_new = (c_ctr == gsbp_pkg::CTR_MAX) ? c_ctr : c_ctr + 1'b1;
    end else begin
      c_ctr_new = (c_ctr == gsbp_pkg::CTR_MIN) ? c_ctr : c_ctr - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q && ctr_clr_en) begin
      ctr_mem[clr_cnt_q[MAX_INDEX_BITS-1:0]] <= gsbp_pkg::CTR_WEAK_TAKEN;
    end else if (c_wr) begin
      ctr_mem[c_idx_q] <= c_ctr_new;
    end
    if (adv) begin
      ctr_rd_q <= ctr_mem[b_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q && lht_clr_en) begin
      lht_mem[clr_cnt_q[MAX_HISTORY_BITS-1:0]] <= '0;
    end else if (c_wr && c_mode_q == gsbp_pkg::MODE_LOCAL) begin
      lht_mem[c_lidx_q] <= c_lht_new_q;
    end
    if (adv) begin
      lht_rd_q <= lht_mem[a_lidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clw_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
    end else if (c_wr) begin
      clw_valid_q <= 1'b1;
      if (c_mode_q == gsbp_pkg::MODE_LOCAL) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_wr) begin
      clw_idx_q  <= c_idx_q;
      clw_data_q <= c_ctr_new;
      if (c_mode_q == gsbp_pkg::MODE_LOCAL) begin
        lw_lidx_q <= c_lidx_q;
        lw_data_q <= c_lht_new_q;
      end
    end
  end

  // output register
  logic prediction_q;
  logic mispredict_q;
  idx_t counter_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_wr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_wr) begin
      prediction_q    <= c_ctr[1];
      mispredict_q    <= c_ctr[1] ^ c_taken_q;
      counter_index_q <= c_idx_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prediction_o    = prediction_q;
  assign mispredict_o    = mispredict_q;
  assign counter_index_o = counter_index_q;

  // checks
  `GSBP_ASSERT(a_clr_pipe_empty, clr_q |-> (!b_valid_q && !c_valid_q),
               "branch in flight during clearing pass")
  `GSBP_NEVER(a_clr_no_update, clr_q && c_wr,
              "counter write-back collides with clearing pass")
  `GSBP_ASSERT(a_no_result_overwrite, c_wr |-> (!out_valid_q || !out_stall_i),
               "result overwritten while output word stalled")
  `GSBP_ASSERT(a_result_follows, (adv && b_valid_q) |=> c_valid_q,
               "branch lost between counter read and write-back")

endmodule
`default_nettype wire
